>>> hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

	localparam int DATA_W     = 32;
	localparam int CAP_W      = 5;
	localparam int RANK_MAX_W = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		REQ_GET = 1'b0,
		REQ_SET = 1'b1
	} req_t;

	// Values rippled from one cell to the next during a lookup.
	typedef struct packed {
		logic                  hit;
		logic                  free_seen;
		logic [RANK_MAX_W-1:0] hit_rank;
		logic [DATA_W-1:0]     hit_value;
	} chain_t;

	// Operation broadcast from the controller to every cell.
	typedef struct packed {
		logic                  exec;
		logic                  is_set;
		logic                  hit;
		logic                  evict;
		logic [RANK_MAX_W-1:0] hit_rank;
		logic [RANK_MAX_W-1:0] victim_rank;
		logic [DATA_W-1:0]     key;
		logic [DATA_W-1:0]     value;
	} op_t;

endpackage

>>> hdl/lkvc_cell.sv
// One cache entry: key, value, valid flag and recency rank, with its chain links.
module lkvc_cell
	import lkvc_pkg::*;
#(
	parameter int RANK_W = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  chain_t chain_in,
	output chain_t chain_out,
	input  op_t    op,
	output logic   valid
);

	logic              valid_q;
	logic [RANK_W-1:0] rank_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;

	logic match;
	logic target;
	logic victim;
	logic set_miss;
	logic load;
	logic age;

	assign match    = valid_q && (key_q == op.key);
	assign target   = !chain_in.free_seen && !valid_q;
	assign victim   = valid_q && (rank_q == op.victim_rank[RANK_W-1:0]);
	assign set_miss = op.is_set && !op.hit;
	assign load     = set_miss && (op.evict ? victim : target);
	assign age      = valid_q && (op.hit ? (rank_q < op.hit_rank[RANK_W-1:0]) : set_miss);

	always_comb begin
		chain_out.hit       = chain_in.hit | match;
		chain_out.free_seen = chain_in.free_seen | !valid_q;
		chain_out.hit_rank  = chain_in.hit_rank |
			(match ? RANK_MAX_W'(rank_q) : '0);
		chain_out.hit_value = chain_in.hit_value | (match ? value_q : '0);
	end

	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (op.exec) begin
			if (load) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (match) begin
				rank_q <= '0;
			end else if (age) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.exec) begin
			if (load) begin
				key_q   <= op.key;
				value_q <= op.value;
			end else if (match && op.is_set) begin
				value_q <= op.value;
			end
		end
	end

endmodule

>>> hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
//
// Requests arrive on the s_ stream: s_tuser carries the request kind (get or
// set) and s_tdata the key and value. Each request yields exactly one result
// transaction on the m_ stream: m_tuser is the hit flag and m_tdata the read
// value (stored value on a get hit, all ones on a get miss, zero on a set).
// The capacity register is written through cfg_valid/cfg_ready/cfg_data and
// should only be changed while no request is in flight.
// Every request is first captured and then executed: all cells compare the
// key in parallel, the hit and the first free slot ripple along the cell
// chain, and every cell updates its rank and contents. The result is then
// held in the output register, and a new request is accepted only once the
// previous one has executed.
// If the receiver stalls, the captured request waits in the execute step until
// the output register frees up; no new request is accepted meanwhile.
// Reset clears all valid flags, ranks and the occupancy count and sets the
// capacity to sixteen.
module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// Request stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*DATA_W-1:0] s_tdata,   // [31:0] key, [63:32] value
	input  logic [0:0]          s_tuser,   // [0] req_type
	// Result stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DATA_W-1:0]   m_tdata,   // [31:0] read_value
	output logic [0:0]          m_tuser,   // [0] hit
	// Capacity register write.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_W-1:0]    cfg_data
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [OCC_W-1:0]  occ_q;
	logic              req_set_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;

	chain_t            chain [ENTRIES+1];
	logic [ENTRIES-1:0] valid_vec;
	op_t               op;

	logic             exec;
	logic             full;
	logic [CMP_W-1:0] cap_eff;
	logic [DATA_W-1:0] result_value;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign exec      = (state_q == ST_EXEC) && (!m_tvalid || m_tready);

	// A capacity of zero behaves as one; the store itself bounds it at ENTRIES.
	assign cap_eff = (capacity_q == '0) ? CMP_W'(1) : CMP_W'(capacity_q);
	assign full    = (CMP_W'(occ_q) >= cap_eff) || (occ_q == OCC_W'(ENTRIES));

	assign chain[0] = '0;

	always_comb begin
		op.exec        = exec;
		op.is_set      = req_set_q;
		op.hit         = chain[ENTRIES].hit;
		op.evict       = full;
		op.hit_rank    = chain[ENTRIES].hit_rank;
		// Valid ranks are always the distinct values 0 .. occupancy-1, so the
		// least recent entry is the one holding rank occupancy-1.
		op.victim_rank = RANK_MAX_W'(occ_q - OCC_W'(1));
		op.key         = key_q;
		op.value       = value_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.RANK_W(RANK_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.chain_in (chain[i]),
			.chain_out(chain[i+1]),
			.op       (op),
			.valid    (valid_vec[i])
		);
	end

	always_comb begin
		if (req_set_q) begin
			result_value = '0;
		end else if (chain[ENTRIES].hit) begin
			result_value = chain[ENTRIES].hit_value;
		end else begin
			result_value = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_set_q <= (req_t'(s_tuser[0]) == REQ_SET);
			key_q     <= s_tdata[DATA_W-1:0];
			value_q   <= s_tdata[2*DATA_W-1:DATA_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			occ_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
					end
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec) begin
						m_tvalid   <= 1'b1;
						m_tdata    <= result_value;
						m_tuser[0] <= chain[ENTRIES].hit;
						if (req_set_q && !chain[ENTRIES].hit && !full) begin
							occ_q <= occ_q + OCC_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Occupancy never exceeds the number of cells.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(ENTRIES))
		else $error("occupancy above entry count");

	// The occupancy count tracks the number of valid cells.
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occ_q))
		else $error("occupancy count differs from valid cells");

	// An executed request always leaves a result and returns to idle.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> (m_tvalid && state_q == ST_IDLE))
		else $error("executed request produced no result");

	// A set never reports a nonzero read value.
	a_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && req_set_q) |=> (m_tdata == '0))
		else $error("set returned nonzero data");

endmodule
